// ----- rtl/touch_wheel_angle_decoder_unit_macros.svh -----
// Assertion macros shared by the touch wheel angle decoder modules.
`ifndef TOUCH_WHEEL_ANGLE_DECODER_UNIT_MACROS_SVH
`define TOUCH_WHEEL_ANGLE_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while reset is low.
`define TWAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twad assertion failed");
// Next-cycle implication, checked while reset is low.
`define TWAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twad assertion failed");
`else
`define TWAD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TWAD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/twad_pkg.sv -----
// Types, constants and the arctangent table of the touch wheel angle decoder.
package twad_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int ATAN_ITERATIONS = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam int SAMPLE_W = 16;
   localparam int DELTA_W  = 8;
   localparam int ANGLE_W  = 15;
   localparam int SECTOR_W = 2;
   localparam int CSR_IDX_W = 3;

   // Signed widths of the position vector terms.
   localparam int XS_W    = 19;  // 2*tC - tB - tA
   localparam int DIFF_W  = 18;  // tB - tA
   localparam int PROD_W  = 36;  // DIFF_W x 18 bit constant
   localparam int CORDIC_W = 38;
   localparam int ACC_W   = 26;
   localparam int ATAN_W  = 22;
   localparam int TABLE_IDX_W = 5;

   localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
   localparam logic [ACC_W-1:0] DEG180_Q16 = ACC_W'(180 * 65536);
   localparam logic [ACC_W-1:0] DEG360_Q16 = ACC_W'(360 * 65536);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DELTA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_XTRA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE    = 3'd5;

   localparam logic [SECTOR_W-1:0] SECTOR_LEFT  = 2'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_DOWN  = 2'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_RIGHT = 2'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_UP    = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] baseline_a;
      logic [SAMPLE_W-1:0] baseline_b;
      logic [SAMPLE_W-1:0] baseline_c;
      logic [DELTA_W-1:0]  press_delta;
      logic [DELTA_W-1:0]  release_extra;
      logic [SAMPLE_W-1:0] reference_level;
   } cfg_type;

   // One classified sample set on its way from the front to the back.
   typedef struct packed {
      logic                     touched;
      logic signed [XS_W-1:0]   x_small;
      logic signed [DIFF_W-1:0] diff;
   } item_type;

   // atan(2^-i) in degrees, Q16.
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [TABLE_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:  val = 22'd2949120;
         5'd1:  val = 22'd1740967;
         5'd2:  val = 22'd919879;
         5'd3:  val = 22'd466945;
         5'd4:  val = 22'd234379;
         5'd5:  val = 22'd117304;
         5'd6:  val = 22'd58666;
         5'd7:  val = 22'd29335;
         5'd8:  val = 22'd14668;
         5'd9:  val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         5'd20: val = 22'd4;
         5'd21: val = 22'd2;
         5'd22: val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/twad_front.sv -----
// Front end: touch hysteresis and electrode weight combination per sample set.
module twad_front (
   input  logic                            clock,
   input  logic                            reset,
   input  twad_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [twad_pkg::SAMPLE_W-1:0]   req_sample_a,
   input  logic [twad_pkg::SAMPLE_W-1:0]   req_sample_b,
   input  logic [twad_pkg::SAMPLE_W-1:0]   req_sample_c,
   output logic                            push_valid,
   input  logic                            push_stall,
   output twad_pkg::item_type              push_data
);

   logic touch_active_ff;
   logic touch_active_in;
   logic accept;

   logic signed [17:0] va, vb, vc;
   logic signed [17:0] on_a, on_b, on_c;
   logic signed [17:0] off_a, off_b, off_c;
   logic [8:0]         off_delta;
   logic               start_touch;
   logic               keep_touch;
   logic               touch_now;
   logic signed [16:0] ta, tb, tc;

   assign req_stall  = push_stall;
   assign push_valid = req_valid;
   assign accept     = req_valid && !push_stall;

   always_comb begin
      va = $signed({2'b00, req_sample_a});
      vb = $signed({2'b00, req_sample_b});
      vc = $signed({2'b00, req_sample_c});
      off_delta = {1'b0, cfg.press_delta} + {1'b0, cfg.release_extra};
      on_a  = $signed({2'b00, cfg.baseline_a}) - $signed({10'd0, cfg.press_delta});
      on_b  = $signed({2'b00, cfg.baseline_b}) - $signed({10'd0, cfg.press_delta});
      on_c  = $signed({2'b00, cfg.baseline_c}) - $signed({10'd0, cfg.press_delta});
      off_a = $signed({2'b00, cfg.baseline_a}) - $signed({9'd0, off_delta});
      off_b = $signed({2'b00, cfg.baseline_b}) - $signed({9'd0, off_delta});
      off_c = $signed({2'b00, cfg.baseline_c}) - $signed({9'd0, off_delta});
      start_touch = (va < on_a) || (vb < on_b) || (vc < on_c);
      keep_touch  = !((va > off_a) && (vb > off_b) && (vc > off_c));
      touch_now   = touch_active_ff ? keep_touch : start_touch;
      touch_active_in = accept ? touch_now : touch_active_ff;

      ta = $signed({1'b0, cfg.reference_level}) - $signed({1'b0, req_sample_a});
      tb = $signed({1'b0, cfg.reference_level}) - $signed({1'b0, req_sample_b});
      tc = $signed({1'b0, cfg.reference_level}) - $signed({1'b0, req_sample_c});

      push_data.touched = touch_now;
      push_data.x_small = ($signed({{2{tc[16]}}, tc}) <<< 1)
                        - $signed({{2{tb[16]}}, tb})
                        - $signed({{2{ta[16]}}, ta});
      push_data.diff    = $signed({tb[16], tb}) - $signed({ta[16], ta});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_active_ff <= 1'b0;
      end else begin
         touch_active_ff <= touch_active_in;
      end
   end

endmodule

// ----- rtl/twad_queue.sv -----
// Short queue that decouples the front end from the arctangent back end.
`include "touch_wheel_angle_decoder_unit_macros.svh"
module twad_queue #(
   parameter int DEPTH = twad_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  twad_pkg::item_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output twad_pkg::item_type out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   twad_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_stall  = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   `TWAD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `TWAD_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `TWAD_ASSERT_NXT(a_count_dn, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

// ----- rtl/twad_back.sv -----
// Back end: iterative vectoring arctangent, rounding, sector map and result register.
`include "touch_wheel_angle_decoder_unit_macros.svh"
module twad_back #(
   parameter int ANGLE_FRAC_BITS = twad_pkg::ANGLE_FRAC_BITS,
   parameter int ATAN_ITERATIONS = twad_pkg::ATAN_ITERATIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_stall,
   input  twad_pkg::item_type              pop_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_touched,
   output logic [twad_pkg::ANGLE_W-1:0]    rsp_angle,
   output logic [twad_pkg::SECTOR_W-1:0]   rsp_sector
);

   localparam int W     = twad_pkg::CORDIC_W;
   localparam int AW    = twad_pkg::ACC_W;
   localparam int IT_W  = $clog2(ATAN_ITERATIONS);
   localparam logic [AW-1:0] FULL_CIRCLE = AW'(360) << ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] HALF_LSB    = AW'(1) << (15 - ANGLE_FRAC_BITS);
   localparam logic [AW-1:0] S45  = AW'(45) << ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] S135 = AW'(135) << ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] S225 = AW'(225) << ANGLE_FRAC_BITS;
   localparam logic [AW-1:0] S315 = AW'(315) << ANGLE_FRAC_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_ITER  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_WRAP  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pop;
   logic       load_out;

   logic                                 touched_ff, touched_in;
   logic                                 zero_ff, zero_in;
   logic signed [twad_pkg::XS_W-1:0]     xs_ff, xs_in;
   logic signed [twad_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [twad_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [W-1:0]                  x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0]                 acc_ff, acc_in;
   logic [IT_W-1:0]                      iter_ff, iter_in;
   logic [AW-1:0]                        q_ff, q_in;
   logic [twad_pkg::ANGLE_W-1:0]         res_angle_ff, res_angle_in;
   logic [twad_pkg::SECTOR_W-1:0]        res_sector_ff, res_sector_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_touched_ff, rsp_touched_in;
   logic [twad_pkg::ANGLE_W-1:0]         rsp_angle_ff, rsp_angle_in;
   logic [twad_pkg::SECTOR_W-1:0]        rsp_sector_ff, rsp_sector_in;

   logic signed [W-1:0]  x0, y0, dx, dy;
   logic [twad_pkg::ATAN_W-1:0] atan_step;
   logic [AW-1:0]        acc_fix;
   logic [AW-1:0]        q_wrap;

   assign pop_stall = (state_ff != S_IDLE);
   assign pop       = pop_valid && !pop_stall;
   assign load_out  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_touched = rsp_touched_ff;
   assign rsp_angle   = rsp_angle_ff;
   assign rsp_sector  = rsp_sector_ff;

   always_comb begin
      state_in      = state_ff;
      touched_in    = touched_ff;
      zero_in       = zero_ff;
      xs_in         = xs_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      iter_in       = iter_ff;
      q_in          = q_ff;
      res_angle_in  = res_angle_ff;
      res_sector_in = res_sector_ff;

      x0 = {{3{xs_ff[twad_pkg::XS_W-1]}}, xs_ff, 16'd0};
      y0 = -{{(W - twad_pkg::PROD_W){prod_ff[twad_pkg::PROD_W-1]}}, prod_ff};
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      atan_step = twad_pkg::atan_q16(twad_pkg::TABLE_IDX_W'(iter_ff));
      acc_fix = acc_ff[AW-1] ? AW'(acc_ff) + twad_pkg::DEG360_Q16 : AW'(acc_ff);
      q_wrap  = (q_ff >= FULL_CIRCLE) ? q_ff - FULL_CIRCLE : q_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               touched_in = pop_data.touched;
               xs_in      = pop_data.x_small;
               diff_in    = pop_data.diff;
               prod_in    = pop_data.diff * twad_pkg::SQRT3_Q16;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            iter_in = '0;
            zero_in = (xs_ff == '0) && (diff_ff == '0);
            if (!touched_ff) begin
               res_angle_in  = '0;
               res_sector_in = twad_pkg::SECTOR_LEFT;
               state_in      = S_OUT;
            end else begin
               // A vector in the left half plane is turned by half a turn first.
               if (xs_ff[twad_pkg::XS_W-1]) begin
                  x_in   = -x0;
                  y_in   = -y0;
                  acc_in = $signed(twad_pkg::DEG180_Q16);
               end else begin
                  x_in   = x0;
                  y_in   = y0;
                  acc_in = '0;
               end
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            if (!y_ff[W-1]) begin
               x_in   = x_ff + dx;
               y_in   = y_ff - dy;
               acc_in = acc_ff + $signed({4'd0, atan_step});
            end else begin
               x_in   = x_ff - dx;
               y_in   = y_ff + dy;
               acc_in = acc_ff - $signed({4'd0, atan_step});
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IT_W'(ATAN_ITERATIONS - 1)) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            q_in     = zero_ff ? '0 : (acc_fix + HALF_LSB) >> (16 - ANGLE_FRAC_BITS);
            state_in = S_WRAP;
         end
         S_WRAP: begin
            res_angle_in = q_wrap[twad_pkg::ANGLE_W-1:0];
            if (q_wrap > S45 && q_wrap <= S135) begin
               res_sector_in = twad_pkg::SECTOR_RIGHT;
            end else if (q_wrap > S135 && q_wrap <= S225) begin
               res_sector_in = twad_pkg::SECTOR_DOWN;
            end else if (q_wrap > S225 && q_wrap <= S315) begin
               res_sector_in = twad_pkg::SECTOR_LEFT;
            end else begin
               res_sector_in = twad_pkg::SECTOR_UP;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_touched_in = rsp_touched_ff;
      rsp_angle_in   = rsp_angle_ff;
      rsp_sector_in  = rsp_sector_ff;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_touched_in = touched_ff;
         rsp_angle_in   = res_angle_ff;
         rsp_sector_in  = res_sector_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      touched_ff     <= touched_in;
      zero_ff        <= zero_in;
      xs_ff          <= xs_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      acc_ff         <= acc_in;
      iter_ff        <= iter_in;
      q_ff           <= q_in;
      res_angle_ff   <= res_angle_in;
      res_sector_ff  <= res_sector_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_angle_ff   <= rsp_angle_in;
      rsp_sector_ff  <= rsp_sector_in;
   end

   `TWAD_ASSERT_IMP(a_untouched_zero, clock, reset, rsp_valid_ff && !rsp_touched_ff,
      rsp_angle_ff == '0 && rsp_sector_ff == twad_pkg::SECTOR_LEFT)
   `TWAD_ASSERT_IMP(a_round_bound, clock, reset, state_ff == S_WRAP, q_ff <= FULL_CIRCLE)
   `TWAD_ASSERT_NXT(a_pop_prep, clock, reset, pop, state_ff == S_PREP)

endmodule

// ----- rtl/touch_wheel_angle_decoder_unit.sv -----
// Top level of the three-electrode touch wheel angle decoder.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_sample_a, req_sample_b, req_sample_c
//   rsp_      out        rsp_valid/rsp_stall  rsp_touched, rsp_angle, rsp_sector
//   csr_      in         csr_write            csr_index, csr_wdata
//
// In the back end a touched transaction passes through the single shared vectoring
// stage, which runs one arctangent step per cycle; an untouched transaction skips it
// and goes from the prepare state straight to the output state.
// Synchronous reset restores the registers, clears the touch flag and empties the queue.
// The front accepts a transaction whenever the queue has room, so up to
// QUEUE_DEPTH transactions can wait while the back end works or the result is stalled.
module touch_wheel_angle_decoder_unit #(
   parameter int ANGLE_FRAC_BITS = twad_pkg::ANGLE_FRAC_BITS,
   parameter int ATAN_ITERATIONS = twad_pkg::ATAN_ITERATIONS,
   parameter int QUEUE_DEPTH     = twad_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [twad_pkg::SAMPLE_W-1:0]    req_sample_a,
   input  logic [twad_pkg::SAMPLE_W-1:0]    req_sample_b,
   input  logic [twad_pkg::SAMPLE_W-1:0]    req_sample_c,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_touched,
   output logic [twad_pkg::ANGLE_W-1:0]     rsp_angle,
   output logic [twad_pkg::SECTOR_W-1:0]    rsp_sector,
   input  logic                             csr_write,
   input  logic [twad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twad_pkg::SAMPLE_W-1:0]    csr_wdata
);

   // Configuration registers. Writes to indexes beyond the list are dropped.
   twad_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            twad_pkg::CSR_BASELINE_A:   cfg_in.baseline_a      = csr_wdata;
            twad_pkg::CSR_BASELINE_B:   cfg_in.baseline_b      = csr_wdata;
            twad_pkg::CSR_BASELINE_C:   cfg_in.baseline_c      = csr_wdata;
            twad_pkg::CSR_PRESS_DELTA:  cfg_in.press_delta     = csr_wdata[7:0];
            twad_pkg::CSR_RELEASE_XTRA: cfg_in.release_extra   = csr_wdata[7:0];
            twad_pkg::CSR_REFERENCE:    cfg_in.reference_level = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_a      <= '0;
         cfg_ff.baseline_b      <= '0;
         cfg_ff.baseline_c      <= '0;
         cfg_ff.press_delta     <= 8'd15;
         cfg_ff.release_extra   <= 8'd5;
         cfg_ff.reference_level <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each transaction and writes it straight into the queue.
   logic               push_valid;
   logic               push_stall;
   twad_pkg::item_type push_data;
   logic               pop_valid;
   logic               pop_stall;
   twad_pkg::item_type pop_data;

   twad_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_a (req_sample_a),
      .req_sample_b (req_sample_b),
      .req_sample_c (req_sample_c),
      .push_valid   (push_valid),
      .push_stall   (push_stall),
      .push_data    (push_data)
   );

   twad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_stall  (push_stall),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_stall (pop_stall),
      .out_data  (pop_data)
   );

   // The back end turns the weight vector into an angle and holds the result
   // in its own output register; a stalled result still lets it pop one more item.
   twad_back #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .ATAN_ITERATIONS (ATAN_ITERATIONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_stall   (pop_stall),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_touched (rsp_touched),
      .rsp_angle   (rsp_angle),
      .rsp_sector  (rsp_sector)
   );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the three-electrode touch wheel angle decoder unit.

// One decoded wheel reading as it leaves the result channel.
typedef struct packed {
   logic                          touched;
   logic [twad_pkg::ANGLE_W-1:0]  angle;
   logic [twad_pkg::SECTOR_W-1:0] sector;
} wheel_reading_type;

// Keeps a private copy of the decoder registers and touch flag, predicts the
// reading for every accepted sample set and compares it with what comes out.
class wheel_tracker;
   wheel_reading_type readings_due[$];
   int unsigned    mismatches;
   logic [15:0]    base_a, base_b, base_c, ref_level;
   logic [7:0]     press, release_more;
   bit             held;
   longint         atan_deg[24];

   function new();
      // atan(2^-i) in degrees, scaled by 2^16.
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
      mismatches   = 0;
      base_a       = '0;
      base_b       = '0;
      base_c       = '0;
      press        = 8'd15;
      release_more = 8'd5;
      ref_level    = 16'd1000;
      held         = 1'b0;
   endfunction

   function void set_register(logic [twad_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
         twad_pkg::CSR_BASELINE_A:   base_a = data;
         twad_pkg::CSR_BASELINE_B:   base_b = data;
         twad_pkg::CSR_BASELINE_C:   base_c = data;
         twad_pkg::CSR_PRESS_DELTA:  press = data[7:0];
         twad_pkg::CSR_RELEASE_XTRA: release_more = data[7:0];
         twad_pkg::CSR_REFERENCE:    ref_level = data;
         default: ;
      endcase
   endfunction

   // Vectoring arctangent of (x, y) in degrees, rounded to the output unit.
   function logic [twad_pkg::ANGLE_W-1:0] wheel_angle(longint x, longint y);
      longint acc, dx, dy, q, full;
      int     i;
      acc  = 0;
      full = longint'(360) << twad_pkg::ANGLE_FRAC_BITS;
      if (x == 0 && y == 0)
         return '0;
      // Fold the left half plane onto the right one.
      if (x < 0) begin
         x   = -x;
         y   = -y;
         acc = 180 * 65536;
      end
      for (i = 0; i < twad_pkg::ATAN_ITERATIONS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x   = x + dx;
            y   = y - dy;
            acc = acc + atan_deg[i];
         end else begin
            x   = x - dx;
            y   = y + dy;
            acc = acc - atan_deg[i];
         end
      end
      if (acc < 0)
         acc = acc + 360 * 65536;
      q = (acc + (longint'(1) << (15 - twad_pkg::ANGLE_FRAC_BITS)))
          >>> (16 - twad_pkg::ANGLE_FRAC_BITS);
      if (q >= full)
         q = q - full;
      return q[twad_pkg::ANGLE_W-1:0];
   endfunction

   function void take_samples(logic [15:0] sa, logic [15:0] sb, logic [15:0] sc);
      int             va, vb, vc, on_lvl, off_lvl;
      longint         lvl, ta, tb, tc, x, y;
      wheel_reading_type due;
      va      = sa;
      vb      = sb;
      vc      = sc;
      on_lvl  = int'(press);
      off_lvl = int'(press) + int'(release_more);
      // Thresholds are signed, so one that falls below zero never fires.
      if (held)
         held = !(va > int'(base_a) - off_lvl && vb > int'(base_b) - off_lvl &&
                  vc > int'(base_c) - off_lvl);
      else
         held = (va < int'(base_a) - on_lvl) || (vb < int'(base_b) - on_lvl) ||
                (vc < int'(base_c) - on_lvl);
      due = '0;
      if (held) begin
         lvl = ref_level;
         ta  = lvl - va;
         tb  = lvl - vb;
         tc  = lvl - vc;
         x   = (2 * tc - tb - ta) * 65536;
         y   = (tb - ta) * 64'sd113512;  // sqrt(3) in Q16
         due.touched = 1'b1;
         due.angle   = wheel_angle(x, -y);
         if (due.angle > (45 << twad_pkg::ANGLE_FRAC_BITS) &&
             due.angle <= (135 << twad_pkg::ANGLE_FRAC_BITS))
            due.sector = twad_pkg::SECTOR_RIGHT;
         else if (due.angle > (135 << twad_pkg::ANGLE_FRAC_BITS) &&
                  due.angle <= (225 << twad_pkg::ANGLE_FRAC_BITS))
            due.sector = twad_pkg::SECTOR_DOWN;
         else if (due.angle > (225 << twad_pkg::ANGLE_FRAC_BITS) &&
                  due.angle <= (315 << twad_pkg::ANGLE_FRAC_BITS))
            due.sector = twad_pkg::SECTOR_LEFT;
         else
            due.sector = twad_pkg::SECTOR_UP;
      end
      readings_due.push_back(due);
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   task check_result(logic touched, logic [twad_pkg::ANGLE_W-1:0] angle,
                     logic [twad_pkg::SECTOR_W-1:0] sector);
      wheel_reading_type due;
      if (readings_due.size() == 0) begin
         report($sformatf("unexpected reading touched=%0d angle=%0d sector=%0d",
                          touched, angle, sector));
         return;
      end
      due = readings_due.pop_front();
      if (touched !== due.touched)
         report($sformatf("touched %0d, predicted %0d", touched, due.touched));
      if (angle !== due.angle)
         report($sformatf("angle %0d, predicted %0d", angle, due.angle));
      if (sector !== due.sector)
         report($sformatf("sector %0d, predicted %0d", sector, due.sector));
   endtask
endclass

module tb_top;

   // Cycles without any accepted transaction on either channel before the run
   // is declared hung. The slowest legal gap is one full arctangent plus any
   // stalled result cycles, well under WATCHDOG_LIMIT.
   localparam int WATCHDOG_LIMIT = 5000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [twad_pkg::SAMPLE_W-1:0]  req_sample_a = '0;
   logic [twad_pkg::SAMPLE_W-1:0]  req_sample_b = '0;
   logic [twad_pkg::SAMPLE_W-1:0]  req_sample_c = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_touched;
   logic [twad_pkg::ANGLE_W-1:0]   rsp_angle;
   logic [twad_pkg::SECTOR_W-1:0]  rsp_sector;
   logic                           csr_write = 1'b0;
   logic [twad_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [twad_pkg::SAMPLE_W-1:0]  csr_wdata = '0;

   // While steady is set neither side inserts idle cycles.
   bit           steady = 1'b0;
   int           idle_cycles = 0;
   int           samples_sent = 0;
   wheel_tracker tracker;

   always #6 clock = ~clock;

   touch_wheel_angle_decoder_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_a (req_sample_a),
      .req_sample_b (req_sample_b),
      .req_sample_c (req_sample_c),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_touched  (rsp_touched),
      .rsp_angle    (rsp_angle),
      .rsp_sector   (rsp_sector),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // The result side stalls in roughly a quarter of the cycles. The decision is
   // made at the falling edge so that it is stable at the next rising edge.
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 24);
   end

   // Every accepted result transaction is checked against the oldest prediction.
   // The same process also runs the watchdog on both channels.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_touched, rsp_angle, rsp_sector);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Offers one sample set and waits until the decoder takes it. Idle cycles are
   // inserted before valid goes up, never while a transaction is pending, so the
   // payload stays put under stall.
   task automatic send_samples(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      do
         @(posedge clock);
      while (req_stall);
      tracker.take_samples(a, b, c);
      samples_sent++;
   endtask

   task automatic write_register(input logic [twad_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [15:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.set_register(idx, data);
   endtask

   // Registers only change once the decoder has drained. Every sample set yields
   // exactly one reading, so an empty prediction queue means the pipe is empty.
   task automatic configure(input logic [15:0] ba, input logic [15:0] bb,
                            input logic [15:0] bc, input logic [7:0] pd,
                            input logic [7:0] rx, input logic [15:0] rl);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.readings_due.size() != 0)
         @(posedge clock);
      write_register(twad_pkg::CSR_BASELINE_A, ba);
      write_register(twad_pkg::CSR_BASELINE_B, bb);
      write_register(twad_pkg::CSR_BASELINE_C, bc);
      write_register(twad_pkg::CSR_PRESS_DELTA, {8'h00, pd});
      write_register(twad_pkg::CSR_RELEASE_XTRA, {8'h00, rx});
      write_register(twad_pkg::CSR_REFERENCE, rl);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] to_sample(int v);
      if (v < 0)
         return 16'h0000;
      if (v > 65535)
         return 16'hFFFF;
      return 16'(v);
   endfunction

   // A finger on the wheel: mostly deep drops, some readings close to the press
   // threshold and a few that sit slightly above the baseline.
   function automatic logic [15:0] pressed(int base, int pd);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return to_sample(base - pd - 1 - int'($urandom_range(0, 30000)));
      if (pick < 80)
         return to_sample(base - int'($urandom_range(0, pd + 40)));
      return to_sample(base + int'($urandom_range(0, 200)));
   endfunction

   // Lift-off readings straddle the release threshold, so some touches hold on.
   function automatic logic [15:0] lifted(int base, int pd, int rx);
      return to_sample(base - pd - rx - 2 + int'($urandom_range(0, pd + rx + 12)));
   endfunction

   function automatic logic [15:0] rail_value();
      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
   endfunction

   // Random part: mostly press/hold/lift gestures with random depth, mixed with
   // uniform noise and rail values, until the running total reaches the goal.
   task automatic play_gestures(input int goal);
      int pick, ba, bb, bc, pd, rx;
      ba = tracker.base_a;
      bb = tracker.base_b;
      bc = tracker.base_c;
      pd = tracker.press;
      rx = tracker.release_more;
      while (samples_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_samples(16'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 20) begin
            send_samples(rail_value(), rail_value(), rail_value());
         end else begin
            repeat ($urandom_range(1, 10))
               send_samples(pressed(ba, pd), pressed(bb, pd), pressed(bc, pd));
            repeat ($urandom_range(1, 3))
               send_samples(lifted(ba, pd, rx), lifted(bb, pd, rx), lifted(bc, pd, rx));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset values: all baselines are zero, so the press threshold is below
      // zero and nothing can register as a touch, not even a rail reading.
      send_samples(16'h0000, 16'h0000, 16'h0000);
      send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF);

      // Directed walk through the hysteresis with press threshold 15 and
      // release threshold 20 below each baseline.
      configure(16'd40000, 16'd30000, 16'd50000, 8'd15, 8'd5, 16'd65535);
      send_samples(16'd40000, 16'd30000, 16'd50000);  // resting level
      send_samples(16'd39985, 16'd30000, 16'd50000);  // exactly on the press level
      send_samples(16'd39984, 16'd30000, 16'd50000);  // one below starts a touch
      send_samples(16'd39980, 16'd30000, 16'd50000);  // on the release level holds
      send_samples(16'd39981, 16'd30000, 16'd50000);  // one above releases
      send_samples(16'd40000, 16'd29984, 16'd50000);  // touch through B
      send_samples(16'd40000, 16'd30000, 16'd50000);  // release
      send_samples(16'd40000, 16'd30000, 16'd49984);  // touch through C
      send_samples(16'd20000, 16'd20000, 16'd20000);  // equal weights, zero vector
      send_samples(16'd0, 16'd0, 16'hFFFF);           // X negative, pointing at 180
      send_samples(16'd0, 16'hFFFF, 16'hFFFF);
      send_samples(16'hFFFF, 16'd0, 16'hFFFF);
      send_samples(16'hFFFF, 16'hFFFF, 16'd0);
      send_samples(16'd0, 16'd0, 16'd0);              // zero vector at the rail
      send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF);     // release at the top rail

      // Extreme settings: zero thresholds at full-scale baselines, then the
      // widest thresholds with a zero reference level.
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 16'hFFFF);
      play_gestures(270);
      configure(16'd0, 16'hFFFF, 16'd32768, 8'd255, 8'd255, 16'd0);
      play_gestures(520);

      // A stretch in which the bench inserts no idle cycles and never stalls the result.
      steady = 1'b1;
      configure(16'd30000, 16'd30000, 16'd30000, 8'd40, 8'd20, 16'd32768);
      play_gestures(820);
      steady = 1'b0;

      repeat (3) begin
         configure(16'($urandom_range(2000, 65535)), 16'($urandom_range(2000, 65535)),
                   16'($urandom_range(2000, 65535)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom));
         play_gestures(samples_sent + 330);
      end

      // Drain, then give the back end time to show any stray reading.
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.readings_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/twad_pkg.sv
rtl/twad_front.sv
rtl/twad_queue.sv
rtl/twad_back.sv
rtl/touch_wheel_angle_decoder_unit.sv
dv/tb_top.sv
